/* hw/rtl/vbt_pkg.sv */
`timescale 1ns / 1ps

package vbt_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_BUCKETS_DEF = 64;
    localparam int QTY_BITS_DEF    = 32;

    // Fixed field and accumulator widths
    localparam int QTY_W   = 32;
    localparam int VOL_W   = 40;
    localparam int CNT_W   = 7;
    localparam int OPEN_W  = 42;
    localparam int SUM_W   = 48;
    localparam int FRAC_W  = 16;
    localparam int RATIO_W = 17;
    localparam int OUT_W   = 24;   // ratio padded to whole bytes

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_W;

    // Configuration register map and reset values
    localparam int CFG_IDX_W = 1;
    localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(1000000);
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUCKET_VOLUME = 1'b0,
        REG_BUCKET_COUNT  = 1'b1
    } t_reg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_CHECK,
        ST_MOD,
        ST_READ,
        ST_DIFF,
        ST_REMOVE,
        ST_INSERT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

endpackage

/* hw/rtl/vbt_ram.sv */
`timescale 1ns / 1ps

module vbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/vbt_div.sv */
`timescale 1ns / 1ps

module vbt_div
    import vbt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SUM_W-1:0]   i_num,
    input  logic [SUM_W-1:0]   i_den,
    output logic               o_done,
    output logic [RATIO_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(FRAC_W);

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [SUM_W-1:0]   r_rem;
    logic [SUM_W-1:0]   r_den;
    logic [RATIO_W-1:0] r_quot;

    logic [SUM_W:0]     w_shift;
    logic               w_fit;

    // Restoring step: remainder stays below the divisor
    assign w_shift = {r_rem, 1'b0};
    assign w_fit   = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0 || i_num >= i_den) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_step <= '0;
                end
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            if (i_den == '0) begin
                r_quot <= '0;
            end else if (i_num >= i_den) begin
                r_quot <= RATIO_ONE;
            end else begin
                r_quot <= '0;
            end
        end else if (r_busy) begin
            r_rem  <= w_fit ? SUM_W'(w_shift - {1'b0, r_den}) : w_shift[SUM_W-1:0];
            r_quot <= {r_quot[RATIO_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* hw/rtl/vpin_volume_bucket_toxicity.sv */
`timescale 1ns / 1ps
// Sequence: a trade that leaves its bucket open passes through ADD, CHECK and DONE;
//   its result is then loaded into the output register and the next trade is taken in IDLE.
// A trade that commits a bucket also runs the bit-serial slot modulo (MOD), READ, DIFF,
//   REMOVE, INSERT and the 16-step divider; the divider steps are skipped when the ratio
//   clamps to one or the window total is zero. Output stalls hold the sequencer in DONE.
// Reset (synchronous, active low) empties bucket and window; ring RAM keeps contents.

module vpin_volume_bucket_toxicity
    import vbt_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int QTY_BITS    = QTY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // trade requests
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [QTY_W-1:0]     s_axis_tdata,   // [31:0] trade_size
    input  logic                 s_axis_tuser,   // [0] buy_side
    // ratio results
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,   // [16:0] vpin_ratio, rest zero
    output logic                 m_axis_tlast,   // bucket_closed
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VOL_W-1:0]     i_cfg_wdata
);

    localparam int SLOT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int N_W     = $clog2(MAX_BUCKETS + 1);
    localparam int X_W     = N_W + 1;
    localparam int MSTEP_W = $clog2(X_W + 1);
    localparam int RING_W  = 2 * OPEN_W;
    localparam logic [QTY_W-1:0] QTY_MASK =
        (QTY_BITS >= QTY_W) ? {QTY_W{1'b1}} : QTY_W'((64'd1 << QTY_BITS) - 64'd1);

    // Configuration registers
    logic [VOL_W-1:0] r_vol;
    logic [CNT_W-1:0] r_cnt;

    // Bucket and window state
    logic [OPEN_W-1:0] r_open_buy;
    logic [OPEN_W-1:0] r_open_sell;
    logic [SLOT_W-1:0] r_head;
    logic [N_W-1:0]    r_fill;
    logic [SUM_W-1:0]  r_sum_abs;
    logic [SUM_W-1:0]  r_sum_tot;
    logic [RATIO_W-1:0] r_ratio;

    // Work registers for the trade in flight
    t_state              r_state;
    t_state              n_state;
    logic [QTY_W-1:0]    r_qty;
    logic                r_buy;
    logic                r_full;
    logic                r_closed;
    logic [X_W-1:0]      r_mod_x;
    logic [N_W-1:0]      r_mod_rem;
    logic [MSTEP_W-1:0]  r_mod_step;
    logic [OPEN_W-1:0]   r_old_ad;
    logic [OPEN_W:0]     r_old_tot;
    logic [OPEN_W-1:0]   r_new_ad;
    logic [OPEN_W:0]     r_new_tot;

    // Output register
    logic               r_out_valid;
    logic [RATIO_W-1:0] r_out_ratio;
    logic               r_out_closed;

    // Control strobes
    logic w_in_ready;
    logic w_ram_re;
    logic w_ram_we;
    logic w_div_start;
    logic w_out_load;

    // Datapath wires
    logic [N_W-1:0]    w_win;
    logic [OPEN_W:0]   w_buy_add;
    logic [OPEN_W:0]   w_sell_add;
    logic [OPEN_W:0]   w_open_tot;
    logic              w_commit;
    logic              w_is_full;
    logic [N_W:0]      w_mod_shift;
    logic              w_mod_fit;
    logic [SLOT_W-1:0] w_slot;
    logic [N_W-1:0]    w_slot_next;
    logic [RING_W-1:0] w_ring_rdata;
    logic [OPEN_W-1:0] w_ring_buy;
    logic [OPEN_W-1:0] w_ring_sell;
    logic [SUM_W:0]    w_abs_add;
    logic [SUM_W:0]    w_tot_add;
    logic              w_div_done;
    logic [RATIO_W-1:0] w_div_quot;

    // Effective window length: bucket count clamped to 1..MAX_BUCKETS
    always_comb begin
        if (r_cnt == '0) begin
            w_win = N_W'(1);
        end else if (32'(r_cnt) > MAX_BUCKETS) begin
            w_win = N_W'(MAX_BUCKETS);
        end else begin
            w_win = N_W'(r_cnt);
        end
    end

    assign w_buy_add  = {1'b0, r_open_buy} + (OPEN_W + 1)'(r_qty);
    assign w_sell_add = {1'b0, r_open_sell} + (OPEN_W + 1)'(r_qty);
    assign w_open_tot = {1'b0, r_open_buy} + {1'b0, r_open_sell};
    assign w_commit   = (w_open_tot >= (OPEN_W + 1)'(r_vol));
    assign w_is_full  = (r_fill >= w_win);

    // Bit-serial modulo by the window length; remainder stays below it
    assign w_mod_shift = {r_mod_rem, r_mod_x[X_W-1]};
    assign w_mod_fit   = (w_mod_shift >= {1'b0, w_win});
    assign w_slot      = r_mod_rem[SLOT_W-1:0];
    assign w_slot_next = N_W'(w_slot) + N_W'(1);

    assign w_ring_buy  = w_ring_rdata[OPEN_W-1:0];
    assign w_ring_sell = w_ring_rdata[RING_W-1:OPEN_W];

    assign w_abs_add = {1'b0, r_sum_abs} + (SUM_W + 1)'(r_new_ad);
    assign w_tot_add = {1'b0, r_sum_tot} + (SUM_W + 1)'(r_new_tot);

    vbt_ram #(
        .WIDTH (RING_W),
        .DEPTH (MAX_BUCKETS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_ram_re),
        .i_addr  (w_slot),
        .i_wdata ({r_open_sell, r_open_buy}),
        .o_rdata (w_ring_rdata)
    );

    vbt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_sum_abs),
        .i_den   (r_sum_tot),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (s_axis_tvalid) n_state = ST_ADD;
            ST_ADD:      n_state = ST_CHECK;
            ST_CHECK:    n_state = w_commit ? ST_MOD : ST_DONE;
            ST_MOD:      if (r_mod_step == MSTEP_W'(X_W - 1)) n_state = ST_READ;
            ST_READ:     n_state = ST_DIFF;
            ST_DIFF:     n_state = ST_REMOVE;
            ST_REMOVE:   n_state = ST_INSERT;
            ST_INSERT:   n_state = ST_DIV_GO;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: if (w_div_done) n_state = ST_DONE;
            ST_DONE:     if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Control strobes
    always_comb begin
        w_in_ready  = (r_state == ST_IDLE);
        w_ram_re    = (r_state == ST_READ);
        w_ram_we    = (r_state == ST_INSERT);
        w_div_start = (r_state == ST_DIV_GO);
        w_out_load  = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vol       <= VOL_RESET;
            r_cnt       <= CNT_RESET;
            r_open_buy  <= '0;
            r_open_sell <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_sum_abs   <= '0;
            r_sum_tot   <= '0;
            r_ratio     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (t_reg_index'(i_cfg_index))
                    REG_BUCKET_VOLUME: r_vol <= i_cfg_wdata;
                    REG_BUCKET_COUNT:  r_cnt <= i_cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end

            // Add the trade to the open bucket, saturating
            if (r_state == ST_ADD) begin
                if (r_buy) begin
                    r_open_buy <= w_buy_add[OPEN_W] ? {OPEN_W{1'b1}} : w_buy_add[OPEN_W-1:0];
                end else begin
                    r_open_sell <= w_sell_add[OPEN_W] ? {OPEN_W{1'b1}}
                                                      : w_sell_add[OPEN_W-1:0];
                end
            end

            // Take the oldest bucket out of the running sums, floor at zero
            if (r_state == ST_REMOVE && r_full) begin
                r_sum_abs <= (r_sum_abs > SUM_W'(r_old_ad))
                           ? SUM_W'(r_sum_abs - SUM_W'(r_old_ad)) : '0;
                r_sum_tot <= (r_sum_tot > SUM_W'(r_old_tot))
                           ? SUM_W'(r_sum_tot - SUM_W'(r_old_tot)) : '0;
            end

            // Commit the open bucket and advance the ring
            if (r_state == ST_INSERT) begin
                r_sum_abs   <= w_abs_add[SUM_W] ? {SUM_W{1'b1}} : w_abs_add[SUM_W-1:0];
                r_sum_tot   <= w_tot_add[SUM_W] ? {SUM_W{1'b1}} : w_tot_add[SUM_W-1:0];
                r_open_buy  <= '0;
                r_open_sell <= '0;
                if (r_full) begin
                    r_head <= (w_slot_next == w_win) ? '0 : w_slot_next[SLOT_W-1:0];
                end else begin
                    r_fill <= r_fill + N_W'(1);
                end
            end

            // Ratio changes only on a commit; hold it for the following trades
            if (r_state == ST_DIV_WAIT && w_div_done) begin
                r_ratio <= w_div_quot;
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_ready && s_axis_tvalid) begin
            r_qty <= s_axis_tdata & QTY_MASK;
            r_buy <= s_axis_tuser;
        end

        if (r_state == ST_CHECK) begin
            r_closed   <= w_commit;
            r_full     <= w_is_full;
            r_mod_x    <= w_is_full ? X_W'(r_head) : X_W'(r_head) + X_W'(r_fill);
            r_mod_rem  <= '0;
            r_mod_step <= '0;
        end

        if (r_state == ST_MOD) begin
            r_mod_x    <= {r_mod_x[X_W-2:0], 1'b0};
            r_mod_rem  <= w_mod_fit ? N_W'(w_mod_shift - {1'b0, w_win})
                                    : w_mod_shift[N_W-1:0];
            r_mod_step <= r_mod_step + MSTEP_W'(1);
        end

        if (r_state == ST_DIFF) begin
            r_old_ad  <= (w_ring_buy > w_ring_sell) ? w_ring_buy - w_ring_sell
                                                    : w_ring_sell - w_ring_buy;
            r_old_tot <= {1'b0, w_ring_buy} + {1'b0, w_ring_sell};
            r_new_ad  <= (r_open_buy > r_open_sell) ? r_open_buy - r_open_sell
                                                    : r_open_sell - r_open_buy;
            r_new_tot <= w_open_tot;
        end

        if (w_out_load) begin
            r_out_ratio  <= r_ratio;
            r_out_closed <= r_closed;
        end
    end

    assign s_axis_tready = w_in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_ratio);
    assign m_axis_tlast  = r_out_closed;

    // Window never holds more buckets than the ring has entries
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= MAX_BUCKETS)
        else $error("ring fill exceeds ring depth");

    // Held ratio never exceeds one
    a_ratio_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ratio <= RATIO_ONE)
        else $error("ratio above one");

    // A commit empties the open bucket
    a_commit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INSERT) |=> (r_open_buy == '0 && r_open_sell == '0))
        else $error("open bucket not cleared after commit");

    // Divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV_WAIT))
        else $error("divider done outside wait state");

    // Ring is written only at a slot inside the window
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (N_W'(w_slot) < w_win))
        else $error("ring slot outside window");

endmodule
